// ===== rtl/xpr_pkg.sv =====
package xpr_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [DataW-1:0] AddConst = 64'h0000_000f_0760_a3c4;
  localparam logic [DataW-1:0] SubConst = 64'h0000_0000_6fa6_24c2;
  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam int unsigned CntW = $clog2(DataW);

  typedef struct packed {
    logic [DataW-1:0] lower_bound;
    logic [DataW-1:0] upper_bound;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] ranged_value;
    logic [DataW-1:0] raw_draw;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADV1 = 5'b00010,
    S_ADV2 = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step_a;
    logic step_b;
    logic div_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic span_zero;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/xorshift_prng_range_draw.sv =====
// 64-bit xorshift generator with range reduction. Each request word carries
// lower and upper bounds; the block advances the generator state and returns
// the raw draw together with (draw mod span) + lower, span = upper - lower + 1
// with 64-bit wrap. When span wraps to zero the draw plus lower is returned.
// A request passes through the state update (ADV1, ADV2), the radix-2 remainder
// unit that resolves one bit per cycle over the 64 draw bits (skipped when the
// span is zero) and the final add into the output register. One request is
// worked on at a time; the next is accepted as soon as the previous result sits
// in the output register, even while that word still waits to be taken. Writing
// the seed register copies the value into the generator state at once; reset
// leaves the state at zero.
module xorshift_prng_range_draw
  import xpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  xpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xpr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/xpr_ctrl.sv =====
module xpr_ctrl
  import xpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ADV1;
        end
      end
      S_ADV1: begin
        cmd_o.step_a = 1'b1;
        state_d      = S_ADV2;
      end
      S_ADV2: begin
        cmd_o.step_b = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        // full range needs no reduction
        if (status_i.span_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/xpr_dp.sv =====
module xpr_dp
  import xpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  in_t              in_data_i,
  input  logic             cfg_valid_i,
  input  logic [DataW-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  logic [DataW-1:0] gen_q, gen_d;
  logic [DataW-1:0] lo_q, hi_q;
  logic [DataW-1:0] mix_q, mix_d;
  logic [DataW-1:0] diff_q;
  logic [DataW-1:0] span_q;
  logic [DataW-1:0] quot_q;
  logic [DataW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [DataW-1:0] adv_t0, adv_t1, adv_u0;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] trial;

  // first half of the update: add, shift left, shift right
  always_comb begin
    adv_t0 = gen_q + AddConst;
    adv_t1 = adv_t0 ^ (adv_t0 << ShiftA);
    mix_d  = adv_t1 ^ (adv_t1 >> ShiftB);
  end

  // second half: subtract, shift left
  always_comb begin
    adv_u0 = mix_q - SubConst;
    gen_d  = adv_u0 ^ (adv_u0 << ShiftC);
  end

  // one restoring division step, remainder only
  always_comb begin
    rem_sh = {rem_q, quot_q[DataW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, span_q};
    if (trial[DataW+1]) begin
      rem_d = rem_sh[DataW-1:0];
    end else begin
      rem_d = trial[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cfg_valid_i) begin
      gen_q <= cfg_data_i;
    end else if (cmd_i.step_b) begin
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q <= in_data_i.lower_bound;
      hi_q <= in_data_i.upper_bound;
    end
    if (cmd_i.step_a) begin
      mix_q  <= mix_d;
      diff_q <= hi_q - lo_q;
    end
    if (cmd_i.step_b) begin
      span_q <= diff_q + {{(DataW-1){1'b0}}, 1'b1};
      quot_q <= gen_d;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_q << 1;
      rem_q  <= rem_d;
      cnt_q  <= cnt_q + {{(CntW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.raw_draw <= gen_q;
      if (span_q == '0) begin
        out_q.ranged_value <= gen_q + lo_q;
      end else begin
        out_q.ranged_value <= rem_q + lo_q;
      end
    end
  end

  assign status_o.span_zero = (span_q == '0);
  assign status_o.div_last  = (cnt_q == {CntW{1'b1}});
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/xpr_draw_checker.sv =====
module xpr_draw_checker
  import xpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  in_t              req_data_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  input  out_t             rsp_data_i,
  input  logic             seed_valid_i,
  input  logic             seed_ready_i,
  input  logic [DataW-1:0] seed_data_i,
  output int unsigned      fail_cnt_o,
  output int unsigned      in_flight_o,
  output int unsigned      checked_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  typedef struct {
    in_t  req;
    out_t draw;
  } draw_exp_t;

  logic [DataW-1:0] gen_state;
  draw_exp_t        expected_draws[$];
  int unsigned      fails;
  int unsigned      checked;

  function automatic logic [DataW-1:0] next_draw(input logic [DataW-1:0] s);
    s = s + AddConst;
    s = s ^ (s << ShiftA);
    s = s ^ (s >> ShiftB);
    s = s - SubConst;
    s = s ^ (s << ShiftC);
    return s;
  endfunction

  function automatic out_t range_reduce(input in_t req, input logic [DataW-1:0] draw);
    logic [DataW-1:0] span;
    out_t             res;
    span = req.upper_bound - req.lower_bound + 64'd1;
    res.raw_draw = draw;
    // span wraps to zero on the full range: no reduction
    if (span == '0) begin
      res.ranged_value = draw + req.lower_bound;
    end else begin
      res.ranged_value = (draw % span) + req.lower_bound;
    end
    return res;
  endfunction

  function automatic void log_mismatch(input string field, input logic [DataW-1:0] exp_v,
                                       input logic [DataW-1:0] act_v, input in_t req);
    fails++;
    if (fails <= MaxReports) begin
      $display("%t: %s mismatch: expected %h got %h (lower %h upper %h)", $realtime,
               field, exp_v, act_v, req.lower_bound, req.upper_bound);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_exp_t e;
    if (!rst_ni) begin
      gen_state = '0;
      expected_draws.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (seed_valid_i && seed_ready_i) begin
        gen_state = seed_data_i;
      end
      if (req_valid_i && req_ready_i) begin
        gen_state = next_draw(gen_state);
        e.req = req_data_i;
        e.draw = range_reduce(req_data_i, gen_state);
        expected_draws.push_back(e);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_draws.size() == 0) begin
          fails++;
          if (fails <= MaxReports) begin
            $display("%t: word with nothing pending: ranged %h raw %h", $realtime,
                     rsp_data_i.ranged_value, rsp_data_i.raw_draw);
          end
        end else begin
          e = expected_draws.pop_front();
          checked++;
          if (rsp_data_i.ranged_value !== e.draw.ranged_value) begin
            log_mismatch("ranged_value", e.draw.ranged_value, rsp_data_i.ranged_value, e.req);
          end
          if (rsp_data_i.raw_draw !== e.draw.raw_draw) begin
            log_mismatch("raw_draw", e.draw.raw_draw, rsp_data_i.raw_draw, e.req);
          end
        end
      end
    end
    fail_cnt_o    <= fails;
    in_flight_o   <= expected_draws.size();
    checked_cnt_o <= checked;
  end

endmodule

// ===== tb/xorshift_prng_range_draw_tb.sv =====
module xorshift_prng_range_draw_tb;
  import xpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseItems    = 245;
  localparam int unsigned QuietItems    = 30;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 80;

  localparam logic [DataW-1:0] AllOnes = '1;
  localparam logic [DataW-1:0] TopBit  = {1'b1, {(DataW-1){1'b0}}};

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [DataW-1:0] cfg_data_i;
  logic             any_accept;

  int unsigned fail_cnt;
  int unsigned in_flight;
  int unsigned checked_cnt;
  int unsigned sent_cnt;
  int unsigned seed_cnt;
  int unsigned full_range_cnt;
  bit          quiet;

  xorshift_prng_range_draw dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  xpr_draw_checker u_draw_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_i   (in_ready_o),
    .req_data_i    (in_data_i),
    .rsp_valid_i   (out_valid_o),
    .rsp_ready_i   (out_ready_i),
    .rsp_data_i    (out_data_o),
    .seed_valid_i  (cfg_valid_i),
    .seed_ready_i  (cfg_ready_o),
    .seed_data_i   (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .in_flight_o   (in_flight),
    .checked_cnt_o (checked_cnt)
  );

  assign any_accept = (in_valid_i & in_ready_o) | (out_valid_o & out_ready_i) |
                      (cfg_valid_i & cfg_ready_o);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 4);
    end else begin
      return $urandom_range(10, 60);
    end
  endfunction

  // leaves valid high on return; the caller sends again or drops it in the same step
  task automatic send_request(input logic [DataW-1:0] lo, input logic [DataW-1:0] hi);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{lower_bound: lo, upper_bound: hi};
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    if (hi - lo + 64'd1 == '0) begin
      full_range_cnt++;
    end
  endtask

  task automatic send_random_request();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    lo = rand64();
    case ($urandom_range(0, 7))
      0: hi = rand64();
      1: hi = lo + {32'd0, $urandom_range(0, 1000)};
      2: hi = lo - 64'd1;
      3: hi = lo + ((64'd1 << $urandom_range(0, 63)) - 64'd1);
      4: hi = lo;
      5: begin
        lo = {32'd0, $urandom_range(0, 15)};
        hi = AllOnes - {32'd0, $urandom_range(0, 15)};
      end
      6: hi = lo + (rand64() >> $urandom_range(0, 63));
      default: begin
        case ($urandom_range(0, 2))
          0: lo = '0;
          1: lo = AllOnes;
          default: lo = TopBit;
        endcase
        hi = rand64();
      end
    endcase
    send_request(lo, hi);
  endtask

  // only once every word is back, so the block is idle
  task automatic write_seed(input logic [DataW-1:0] seed);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_cnt++;
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          stall = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if (any_accept) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no handshake for %0d cycles, %0d words outstanding", idle, in_flight);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [DataW-1:0] seed;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    quiet          = 1'b0;
    sent_cnt       = 0;
    seed_cnt       = 0;
    full_range_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // generator still at its reset value of zero
    send_request('0, AllOnes);
    send_request(64'd1, '0);
    send_request(TopBit, TopBit - 64'd1);
    send_request('0, '0);
    send_request(AllOnes, AllOnes);
    send_request('0, 64'd1);
    send_request(AllOnes, '0);
    send_request(64'd10, 64'd3);
    send_request('0, AllOnes - 64'd1);
    send_request(64'd1, AllOnes);
    send_request('0, TopBit);
    send_request('0, TopBit - 64'd1);
    send_request(64'h5555_5555_5555_5555, 64'h5555_5555_5556_5554);

    write_seed(AllOnes);
    send_request('0, AllOnes);
    send_request(AllOnes, AllOnes);
    send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_request('0, 64'd6);

    write_seed(TopBit);
    send_request(64'd7, 64'd6);
    send_request(AllOnes, 64'd99);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: seed = '0;
        1: seed = AllOnes;
        2: seed = TopBit | 64'd1;
        default: seed = rand64();
      endcase
      quiet = 1'b1;
      write_seed(seed);
      for (int i = 0; i < PhaseItems; i++) begin
        quiet = (i < QuietItems);
        send_random_request();
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (in_flight != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d range requests (%0d full-range spans) over reset seed and %0d seed writes",
             sent_cnt, full_range_cnt, seed_cnt);
    $display("run: %0d result words checked, %0d failures", checked_cnt, fail_cnt);
    if (fail_cnt == 0 && in_flight == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xpr_pkg.sv
rtl/xpr_ctrl.sv
rtl/xpr_dp.sv
rtl/xorshift_prng_range_draw.sv
tb/xpr_draw_checker.sv
tb/xorshift_prng_range_draw_tb.sv
